### rtl/cpt_pkg.sv
// Package for the cyclic prefix timing detector: constants, codes,
// payload structs and the multiply-accumulate schedule table.
// No dependencies.
`default_nettype none

package cpt_pkg;

    // Defaults for the top level parameters
    localparam int DEF_MAX_FFT_SIZE  = 1024;
    localparam int DEF_MAX_CP_LENGTH = 256;
    localparam int DEF_SAMPLE_WIDTH  = 16;
    localparam int DEF_OFFSET_WIDTH  = 16;

    // Fixed datapath widths
    localparam int SUM_W     = 64;               // running sums, modulo 2^64
    localparam int NORM_W    = 22;               // normalized magnitude width
    localparam int MUL_W     = NORM_W + 1;       // signed multiplier operand
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DEN_W     = 2 * NORM_W;       // S^2
    localparam int NUM_SHIFT = 17;               // times 4 * 32768
    localparam int NUM_W     = DEN_W + NUM_SHIFT + 1;
    localparam int Q_W       = 19;               // quotient stays below 2^19
    localparam int STEP_W    = 5;
    localparam int MAC_STEPS = 16;
    localparam int SQ_STEPS  = 3;
    localparam int PADDR_W   = 4;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Register reset values
    localparam logic [10:0] RST_FFT_SIZE    = 11'd128;
    localparam logic [8:0]  RST_CP_LENGTH   = 9'd32;
    localparam logic [15:0] RST_THRESHOLD   = 16'd27853;
    localparam logic [15:0] RST_DROP_RATIO  = 16'd22938;

    typedef enum logic [1:0] {
        REG_FFT_SIZE,
        REG_CP_LENGTH,
        REG_THRESHOLD,
        REG_DROP_RATIO
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACC_CORR_RE,
        ACC_CORR_IM,
        ACC_LATE,
        ACC_EARLY
    } t_acc_sel;

    // Which stored sample feeds a multiplier operand
    typedef enum logic [1:0] {
        OPD_A,      // lagged sample, entering the window
        OPD_B,      // lagged sample, leaving the window
        OPD_C,      // recent sample, leaving the window
        OPD_X       // new sample
    } t_opd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_WR,
        ST_MAC,
        ST_POST,
        ST_SUM,
        ST_MAG,
        ST_CMP,
        ST_NORM,
        ST_SQ,
        ST_DIV,
        ST_SRCH0,
        ST_SRCH1,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] sample_i;
        logic signed [15:0] sample_q;
        logic               frame_start;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] metric;
        logic [15:0] window_offset;
        logic        search_done;
        logic        peak_found;
        logic [15:0] peak_offset;
    } t_out_item;

    typedef struct packed {
        t_opd     src_a;
        logic     a_q;
        t_opd     src_b;
        logic     b_q;
        t_acc_sel sel;
        logic     sub;
    } t_mac_op;

    // One product per step; the upper half removes the window's oldest terms
    function automatic t_mac_op mac_op(input logic [3:0] step);
        t_mac_op op;
        case (step)
            4'd0:    op = '{OPD_A, 1'b0, OPD_X, 1'b0, ACC_CORR_RE, 1'b0};
            4'd1:    op = '{OPD_A, 1'b1, OPD_X, 1'b1, ACC_CORR_RE, 1'b0};
            4'd2:    op = '{OPD_A, 1'b1, OPD_X, 1'b0, ACC_CORR_IM, 1'b0};
            4'd3:    op = '{OPD_A, 1'b0, OPD_X, 1'b1, ACC_CORR_IM, 1'b1};
            4'd4:    op = '{OPD_X, 1'b0, OPD_X, 1'b0, ACC_LATE,    1'b0};
            4'd5:    op = '{OPD_X, 1'b1, OPD_X, 1'b1, ACC_LATE,    1'b0};
            4'd6:    op = '{OPD_A, 1'b0, OPD_A, 1'b0, ACC_EARLY,   1'b0};
            4'd7:    op = '{OPD_A, 1'b1, OPD_A, 1'b1, ACC_EARLY,   1'b0};
            4'd8:    op = '{OPD_B, 1'b0, OPD_C, 1'b0, ACC_CORR_RE, 1'b1};
            4'd9:    op = '{OPD_B, 1'b1, OPD_C, 1'b1, ACC_CORR_RE, 1'b1};
            4'd10:   op = '{OPD_B, 1'b1, OPD_C, 1'b0, ACC_CORR_IM, 1'b1};
            4'd11:   op = '{OPD_B, 1'b0, OPD_C, 1'b1, ACC_CORR_IM, 1'b0};
            4'd12:   op = '{OPD_C, 1'b0, OPD_C, 1'b0, ACC_LATE,    1'b1};
            4'd13:   op = '{OPD_C, 1'b1, OPD_C, 1'b1, ACC_LATE,    1'b1};
            4'd14:   op = '{OPD_B, 1'b0, OPD_B, 1'b0, ACC_EARLY,   1'b1};
            default: op = '{OPD_B, 1'b1, OPD_B, 1'b1, ACC_EARLY,   1'b1};
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### rtl/cpt_dline.sv
// Sample delay memory of the cyclic prefix timing detector.
// One write port, one registered read port. Uses cpt_pkg.
`default_nettype none

module cpt_dline
    import cpt_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_FFT_SIZE + DEF_MAX_CP_LENGTH,
    parameter int WORD_W = 2 * DEF_SAMPLE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WORD_W-1:0]        o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/cpt_mul.sv
// Shared signed multiplier with a registered product.
// Uses cpt_pkg for widths.
`default_nettype none

module cpt_mul
    import cpt_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

`default_nettype wire

### rtl/cpt_div.sv
// Restoring divider, one quotient bit per cycle, for the metric quotient.
// Uses cpt_pkg for widths.
`default_nettype none

module cpt_div
    import cpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_q
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic             fits;

    assign fits   = (r_rem >= r_dsh);
    assign o_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Quotient is known to stay below 2^Q_W, so start at den << (Q_W-1)
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NUM_W'(i_den) << (Q_W - 1);
            o_q   <= '0;
        end else if (o_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            o_q   <= {o_q[Q_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

### rtl/cyclic_prefix_timing_detector_unit.sv
// Cyclic prefix timing detector, top level: sequencer, running sums, search.
// Depends on cpt_pkg, cpt_dline, cpt_mul and cpt_div.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------
//  in        to block   i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  out       from block o_out_valid / i_out_ready o_out_data (t_out_item)
//  config    to block   psel, penable, pready     paddr, pwdata, prdata
//
//  One request at a time. A sample that gives no result passes through
//  accept, three delay-memory reads and a write, 16 products through the
//  single multiplier and one update step. A sample that gives a result
//  adds the metric: a normalize shift, three squares, a divide and the
//  peak compare; the shift, squares and divide are skipped when the
//  window power is zero or the metric saturates. The memory port and
//  the one multiplier make these steps run one after another.
//  Reset is synchronous, active low; the delay memory is not cleared.
//  A result waits in the output register while the next request is taken;
//  a second result waits in the sequencer until that register frees.
`default_nettype none

module cyclic_prefix_timing_detector_unit
    import cpt_pkg::*;
#(
    parameter int MAX_FFT_SIZE  = DEF_MAX_FFT_SIZE,
    parameter int MAX_CP_LENGTH = DEF_MAX_CP_LENGTH,
    parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
    parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH    = MAX_FFT_SIZE + MAX_CP_LENGTH;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LAG_W    = $clog2(MAX_FFT_SIZE + 1);
    localparam int CPL_W    = $clog2(MAX_CP_LENGTH + 1);
    localparam int WIN_W    = $clog2(DEPTH + 1);
    localparam int SW       = SAMPLE_WIDTH;
    localparam int SEEN_CAP = 65536 + DEPTH + 1;
    localparam int SEEN_W   = $clog2(SEEN_CAP + 1);
    localparam int OFF_CAP  = (OFFSET_WIDTH >= 16) ? 65535 : (2 ** OFFSET_WIDTH - 1);

    // ---------------- configuration registers ----------------
    logic [10:0] r_fft_size;
    logic [8:0]  r_cp_length;
    logic [15:0] r_threshold;
    logic [15:0] r_drop_ratio;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FFT_SIZE:   prdata = 32'(r_fft_size);
            REG_CP_LENGTH:  prdata = 32'(r_cp_length);
            REG_THRESHOLD:  prdata = 32'(r_threshold);
            REG_DROP_RATIO: prdata = 32'(r_drop_ratio);
            default:        prdata = '0;
        endcase
    end

    // Clamp the registers to the lengths the memory can hold; zero reads as one
    logic [LAG_W-1:0]  n_lag;
    logic [CPL_W-1:0]  c_len;
    logic [WIN_W-1:0]  win_len;

    always_comb begin
        if (r_fft_size == '0) begin
            n_lag = LAG_W'(1);
        end else if (32'(r_fft_size) > 32'(MAX_FFT_SIZE)) begin
            n_lag = LAG_W'(MAX_FFT_SIZE);
        end else begin
            n_lag = LAG_W'(r_fft_size);
        end
        if (r_cp_length == '0) begin
            c_len = CPL_W'(1);
        end else if (32'(r_cp_length) > 32'(MAX_CP_LENGTH)) begin
            c_len = CPL_W'(MAX_CP_LENGTH);
        end else begin
            c_len = CPL_W'(r_cp_length);
        end
        win_len = WIN_W'(n_lag) + WIN_W'(c_len);
    end

    // ---------------- state ----------------
    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_wr_pos;
    logic [SEEN_W-1:0] r_seen, r_n;
    logic [SUM_W-1:0]  r_corr_re, r_corr_im, r_early, r_late;
    logic [15:0]       r_best, r_best_off;
    logic              r_have_peak, r_finished;
    logic              r_out_valid;
    t_out_item         r_out;

    logic signed [SW-1:0] r_xi, r_xq;
    logic                 r_fe;
    logic [2*SW-1:0]      r_a, r_b, r_c;
    logic [SUM_W-1:0]     r_s, r_mr, r_mi;
    logic [DEN_W:0]       r_sq_sum;
    logic [15:0]          r_metric, r_off;
    logic                 r_done;

    // ---------------- shared units ----------------
    logic                     mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic [2*SW-1:0]          mem_rd_data;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     div_start, div_busy;
    logic [Q_W-1:0]           div_q;

    cpt_dline #(
        .DEPTH  (DEPTH),
        .WORD_W (2 * SW)
    ) u_dline (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_wr_pos),
        .i_wr_data ({r_xq, r_xi}),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    cpt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_sq_sum, NUM_SHIFT'(0)}),
        .i_den   (mul_p[DEN_W-1:0]),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    // ---------------- delay memory addresses ----------------
    logic [ADDR_W:0]   base, tmp_a, tmp_b, tmp_c;
    logic [ADDR_W-1:0] addr_a, addr_b, addr_c;

    always_comb begin
        base   = (ADDR_W + 1)'(r_wr_pos) + (ADDR_W + 1)'(DEPTH);
        tmp_a  = base - (ADDR_W + 1)'(n_lag);
        tmp_b  = base - (ADDR_W + 1)'(win_len);
        tmp_c  = base - (ADDR_W + 1)'(c_len);
        addr_a = (tmp_a >= (ADDR_W + 1)'(DEPTH)) ?
                 ADDR_W'(tmp_a - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(tmp_a);
        addr_b = (tmp_b >= (ADDR_W + 1)'(DEPTH)) ?
                 ADDR_W'(tmp_b - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(tmp_b);
        addr_c = (tmp_c >= (ADDR_W + 1)'(DEPTH)) ?
                 ADDR_W'(tmp_c - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(tmp_c);
    end

    // ---------------- decoded helpers ----------------
    logic              in_acc;
    logic              out_free;
    logic              add_on, sub_on;
    logic              short_win;
    logic [SEEN_W:0]   n_plus;
    logic [SEEN_W:0]   off_raw;
    logic [SUM_W-1:0]  sum_s;
    logic              s_nonpos;
    logic              too_big;
    logic              big_s;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign add_on    = (r_n >= SEEN_W'(n_lag));
    assign sub_on    = (r_n >= SEEN_W'(win_len));
    assign n_plus    = (SEEN_W + 1)'(r_n) + 1'b1;
    assign short_win = (n_plus < (SEEN_W + 1)'(win_len));
    assign off_raw   = n_plus - (SEEN_W + 1)'(win_len);
    assign sum_s     = r_early + r_late;
    assign s_nonpos  = r_s[SUM_W-1] || (r_s == '0);
    assign too_big   = (r_mr >= r_s) || (r_mi >= r_s);
    assign big_s     = (r_s[SUM_W-1:NORM_W] != '0);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_RD_A;
            ST_RD_A:  n_state = ST_RD_B;
            ST_RD_B:  n_state = ST_RD_C;
            ST_RD_C:  n_state = ST_WR;
            ST_WR:    n_state = ST_MAC;
            ST_MAC:   if (r_step == STEP_W'(MAC_STEPS)) n_state = ST_POST;
            ST_POST: begin
                if (r_finished) begin
                    n_state = ST_IDLE;
                end else if (short_win) begin
                    n_state = r_fe ? ST_OUT : ST_IDLE;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:   n_state = ST_MAG;
            ST_MAG:   n_state = s_nonpos ? ST_SRCH0 : ST_CMP;
            ST_CMP:   n_state = too_big ? ST_SRCH0 : ST_NORM;
            ST_NORM:  if (!big_s) n_state = ST_SQ;
            ST_SQ:    if (r_step == STEP_W'(SQ_STEPS)) n_state = ST_DIV;
            ST_DIV:   if (!div_busy) n_state = ST_SRCH0;
            ST_SRCH0: n_state = ST_SRCH1;
            ST_SRCH1: n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    t_mac_op               op_issue, op_acc;
    logic [3:0]            acc_idx;
    logic [2*SW-1:0]       word_a, word_b;
    logic signed [SW-1:0]  smp_a, smp_b;
    logic                  acc_en;

    always_comb begin
        acc_idx  = 4'(r_step - 1'b1);
        op_issue = mac_op(r_step[3:0]);
        op_acc   = mac_op(acc_idx);

        case (op_issue.src_a)
            OPD_A:   word_a = r_a;
            OPD_B:   word_a = r_b;
            OPD_C:   word_a = r_c;
            default: word_a = {r_xq, r_xi};
        endcase
        case (op_issue.src_b)
            OPD_A:   word_b = r_a;
            OPD_B:   word_b = r_b;
            OPD_C:   word_b = r_c;
            default: word_b = {r_xq, r_xi};
        endcase
        smp_a = op_issue.a_q ? word_a[2*SW-1:SW] : word_a[SW-1:0];
        smp_b = op_issue.b_q ? word_b[2*SW-1:SW] : word_b[SW-1:0];

        o_in_ready  = (r_state == ST_IDLE);
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_a;
        mem_wr_en   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        acc_en      = 1'b0;

        case (r_state)
            ST_RD_A: begin
                mem_rd_en = 1'b1;
            end
            ST_RD_B: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_b;
            end
            ST_RD_C: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_c;
            end
            ST_WR: begin
                mem_wr_en = 1'b1;
            end
            ST_MAC: begin
                mul_a  = MUL_W'(smp_a);
                mul_b  = MUL_W'(smp_b);
                // product of the previous step lands now; the upper half of
                // the schedule drops the oldest terms once the window is full
                acc_en = (r_step != '0) && (acc_idx[3] ? sub_on : add_on);
            end
            ST_SQ: begin
                case (r_step)
                    STEP_W'(0): begin
                        mul_a = {1'b0, r_mr[NORM_W-1:0]};
                        mul_b = {1'b0, r_mr[NORM_W-1:0]};
                    end
                    STEP_W'(1): begin
                        mul_a = {1'b0, r_mi[NORM_W-1:0]};
                        mul_b = {1'b0, r_mi[NORM_W-1:0]};
                    end
                    STEP_W'(2): begin
                        mul_a = {1'b0, r_s[NORM_W-1:0]};
                        mul_b = {1'b0, r_s[NORM_W-1:0]};
                    end
                    default: begin
                        div_start = 1'b1;
                    end
                endcase
            end
            ST_SRCH0: begin
                mul_a = MUL_W'(r_best);
                mul_b = MUL_W'(r_drop_ratio);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // ---------------- accumulator ----------------
    logic [SUM_W-1:0] acc_cur, acc_new, prod_ext;

    always_comb begin
        prod_ext = {{(SUM_W - PROD_W){mul_p[PROD_W-1]}}, mul_p};
        case (op_acc.sel)
            ACC_CORR_RE: acc_cur = r_corr_re;
            ACC_CORR_IM: acc_cur = r_corr_im;
            ACC_LATE:    acc_cur = r_late;
            default:     acc_cur = r_early;
        endcase
        acc_new = op_acc.sub ? (acc_cur - prod_ext) : (acc_cur + prod_ext);
    end

    // ---------------- peak search ----------------
    logic        upd_peak, drop_hit, done_now;

    always_comb begin
        upd_peak = (r_metric > r_best) && (r_metric > r_threshold);
        drop_hit = r_have_peak && ({1'b0, r_metric, 15'b0} < mul_p[31:0]);
        done_now = (!upd_peak && drop_hit) || r_fe;
    end

    // ---------------- control and frame state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_wr_pos     <= '0;
            r_seen       <= '0;
            r_corr_re    <= '0;
            r_corr_im    <= '0;
            r_early      <= '0;
            r_late       <= '0;
            r_best       <= '0;
            r_best_off   <= '0;
            r_have_peak  <= 1'b0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fft_size   <= RST_FFT_SIZE;
            r_cp_length  <= RST_CP_LENGTH;
            r_threshold  <= RST_THRESHOLD;
            r_drop_ratio <= RST_DROP_RATIO;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_FFT_SIZE:   r_fft_size   <= pwdata[10:0];
                    REG_CP_LENGTH:  r_cp_length  <= pwdata[8:0];
                    REG_THRESHOLD:  r_threshold  <= pwdata[15:0];
                    REG_DROP_RATIO: r_drop_ratio <= pwdata[15:0];
                    default:        r_threshold  <= r_threshold;
                endcase
            end

            // frame start clears sums and search on acceptance
            if (in_acc && i_in_data.frame_start) begin
                r_corr_re   <= '0;
                r_corr_im   <= '0;
                r_early     <= '0;
                r_late      <= '0;
                r_best      <= '0;
                r_best_off  <= '0;
                r_have_peak <= 1'b0;
                r_finished  <= 1'b0;
            end

            if (r_state == ST_WR) begin
                r_wr_pos <= (r_wr_pos == ADDR_W'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
            end

            // step counter for the multiply passes
            if ((r_state == ST_MAC && r_step != STEP_W'(MAC_STEPS)) ||
                (r_state == ST_SQ && r_step != STEP_W'(SQ_STEPS))) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end

            if (acc_en) begin
                case (op_acc.sel)
                    ACC_CORR_RE: r_corr_re <= acc_new;
                    ACC_CORR_IM: r_corr_im <= acc_new;
                    ACC_LATE:    r_late    <= acc_new;
                    default:     r_early   <= acc_new;
                endcase
            end

            if (r_state == ST_POST) begin
                r_seen <= (r_n < SEEN_W'(SEEN_CAP)) ? r_n + 1'b1 : r_n;
                if (!r_finished && short_win && r_fe) begin
                    r_finished <= 1'b1;
                end
            end

            if (r_state == ST_SRCH1) begin
                if (upd_peak) begin
                    r_best      <= r_metric;
                    r_best_off  <= r_off;
                    r_have_peak <= 1'b1;
                end
                r_finished <= done_now;
            end

            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_xi <= i_in_data.sample_i[SW-1:0];
            r_xq <= i_in_data.sample_q[SW-1:0];
            r_fe <= i_in_data.frame_end;
            r_n  <= i_in_data.frame_start ? '0 : r_seen;
        end

        case (r_state)
            ST_RD_B: r_a <= mem_rd_data;
            ST_RD_C: r_b <= mem_rd_data;
            ST_WR:   r_c <= mem_rd_data;
            ST_POST: begin
                // short window at frame end: report metric 0 at offset 0
                r_metric <= '0;
                r_done   <= 1'b1;
                if (short_win) begin
                    r_off <= '0;
                end else if (off_raw > (SEEN_W + 1)'(OFF_CAP)) begin
                    r_off <= 16'(OFF_CAP);
                end else begin
                    r_off <= 16'(off_raw);
                end
            end
            ST_SUM: begin
                r_s  <= sum_s;
                r_mr <= r_corr_re[SUM_W-1] ? (~r_corr_re + 1'b1) : r_corr_re;
            end
            ST_MAG: begin
                r_mi     <= r_corr_im[SUM_W-1] ? (~r_corr_im + 1'b1) : r_corr_im;
                r_metric <= '0;
            end
            ST_CMP: begin
                r_metric <= ONE_Q15;
            end
            ST_NORM: begin
                if (big_s) begin
                    r_s  <= r_s >> 1;
                    r_mr <= r_mr >> 1;
                    r_mi <= r_mi >> 1;
                end
            end
            ST_SQ: begin
                if (r_step == STEP_W'(1)) begin
                    r_sq_sum <= (DEN_W + 1)'(mul_p[DEN_W-1:0]);
                end else if (r_step == STEP_W'(2)) begin
                    r_sq_sum <= r_sq_sum + (DEN_W + 1)'(mul_p[DEN_W-1:0]);
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    r_metric <= (div_q > Q_W'(ONE_Q15)) ? ONE_Q15 : div_q[15:0];
                end
            end
            ST_SRCH1: begin
                r_done <= done_now;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.metric        <= r_metric;
                    r_out.window_offset <= r_off;
                    r_out.search_done   <= r_done;
                    r_out.peak_found    <= r_have_peak;
                    r_out.peak_offset   <= r_best_off;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
